@@ rtl/ca_res_pkg.sv @@
// ----------------------------------------------------------------------------
// ca_res_pkg
// Shared types, constants and cell update functions for the cellular
// automaton reservoir step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ca_res_pkg;

    localparam int CELL_W         = 2;
    localparam int NUM_STATES_W   = 2;
    localparam int RULE_W         = 54;
    localparam int ITER_W         = 5;
    localparam int MAP_W          = 48;
    localparam int MAP_FIELD_W    = 3;
    localparam int MAP_RES_STRIDE = 12;
    localparam int SYMBOL_COUNT   = 4;
    localparam int RESTART_BIT    = 8;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 64;
    localparam int M_TUSER_W      = 4;
    localparam int OUT_CELLS      = 32;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 54;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_STATES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_TABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITERATIONS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_MAP  = 2'd3;

    localparam logic [NUM_STATES_W-1:0] NUM_STATES_RESET = 2'd3;
    localparam logic [ITER_W-1:0]       ITERATIONS_RESET = 5'd4;

    typedef logic [CELL_W-1:0] cell_t;

    localparam cell_t START_THREE = 2'd2;
    localparam cell_t START_TWO   = 2'd0;

    localparam logic [4:0] RULE_LAST_THREE = 5'd26;
    localparam logic [4:0] RULE_LAST_TWO   = 5'd7;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_gen;
        logic out_free;
    } ctrl_sts_t;

    // clamp a cell or rule value to S-1
    function automatic cell_t clamp_digit(cell_t c, logic three);
        cell_t d;
        if (three) begin
            d = (c == 2'd3) ? 2'd2 : c;
        end else begin
            d = (c != 2'd0) ? 2'd1 : 2'd0;
        end
        return d;
    endfunction

    function automatic cell_t next_cell(cell_t l, cell_t c, cell_t r, logic three,
                                        logic [RULE_W-1:0] rule);
        logic [4:0] dl;
        logic [4:0] dc;
        logic [4:0] dr;
        logic [4:0] val;
        logic [4:0] k;
        cell_t      e;
        dl = {3'b000, clamp_digit(l, three)};
        dc = {3'b000, clamp_digit(c, three)};
        dr = {3'b000, clamp_digit(r, three)};
        if (three) begin
            val = (dl << 3) + dl + (dc << 1) + dc + dr;
            k   = RULE_LAST_THREE - val;
        end else begin
            val = (dl << 2) + (dc << 1) + dr;
            k   = RULE_LAST_TWO - val;
        end
        e = CELL_W'(rule >> {k, 1'b0});
        return clamp_digit(e, three);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ca_res_ctrl.sv @@
// ----------------------------------------------------------------------------
// ca_res_ctrl
// Controller: accepts an item, then steps one generation per cycle while the
// output register is free, until the last generation is produced.
// ----------------------------------------------------------------------------
`default_nettype none

module ca_res_ctrl
    import ca_res_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output ctrl_cmd_t      cmd,
    input  wire ctrl_sts_t sts
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.step = (state_reg == ST_RUN) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cmd.step && sts.last_gen) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ca_res_dp.sv @@
// ----------------------------------------------------------------------------
// ca_res_dp
// Datapath: configuration registers, cell row, symbol injection, combinational
// generation update, generation counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ca_res_dp
    import ca_res_pkg::*;
#(
    parameter int RESERVOIRS       = 4,
    parameter int RESERVOIR_LENGTH = 8,
    parameter int INPUT_COUNT      = 4,
    parameter int MAX_ITERATIONS   = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [M_TDATA_W-1:0]        m_tdata,
    output logic [M_TUSER_W-1:0]        m_tuser,
    output logic                        m_tlast,
    input  wire ctrl_cmd_t              cmd,
    output ctrl_sts_t                   sts
);

    localparam int CELLS = RESERVOIRS * RESERVOIR_LENGTH;
    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
    localparam int EW    = (CNT_W > ITER_W) ? CNT_W : ITER_W;

    logic [NUM_STATES_W-1:0] num_states_reg;
    logic [RULE_W-1:0]       rule_table_reg;
    logic [ITER_W-1:0]       iterations_reg;
    logic [MAP_W-1:0]        input_map_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_states_reg <= NUM_STATES_RESET;
            rule_table_reg <= '0;
            iterations_reg <= ITERATIONS_RESET;
            input_map_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NUM_STATES: num_states_reg <= cfg_wdata[NUM_STATES_W-1:0];
                CFG_RULE_TABLE: rule_table_reg <= cfg_wdata[RULE_W-1:0];
                CFG_ITERATIONS: iterations_reg <= cfg_wdata[ITER_W-1:0];
                CFG_INPUT_MAP:  input_map_reg  <= cfg_wdata[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    logic  three;
    cell_t start_val;
    logic  restart;

    assign three     = (num_states_reg == 2'd3);
    assign start_val = three ? START_THREE : START_TWO;
    assign restart   = s_tdata[RESTART_BIT];

    cell_t sym [SYMBOL_COUNT];
    for (genvar j = 0; j < SYMBOL_COUNT; j++) begin : g_sym
        assign sym[j] = s_tdata[CELL_W*j +: CELL_W];
    end

    // mapped offsets, reduced by the reservoir length when at or above it
    logic [MAP_FIELD_W-1:0] off_mod [RESERVOIRS][INPUT_COUNT];
    for (genvar r = 0; r < RESERVOIRS; r++) begin : g_res
        for (genvar j = 0; j < INPUT_COUNT; j++) begin : g_in
            localparam int POS = MAP_RES_STRIDE * r + MAP_FIELD_W * j;
            logic [MAP_FIELD_W-1:0] off_raw;
            if (POS + MAP_FIELD_W <= MAP_W) begin : g_map
                assign off_raw = input_map_reg[POS +: MAP_FIELD_W];
            end else begin : g_zero
                assign off_raw = '0;
            end
            if (RESERVOIR_LENGTH < (1 << MAP_FIELD_W)) begin : g_wrap
                assign off_mod[r][j] = (off_raw >= MAP_FIELD_W'(RESERVOIR_LENGTH)) ?
                                       off_raw - MAP_FIELD_W'(RESERVOIR_LENGTH) : off_raw;
            end else begin : g_keep
                assign off_mod[r][j] = off_raw;
            end
        end
    end

    cell_t row_reg  [CELLS];
    cell_t inj_cells[CELLS];
    cell_t gen_cells[CELLS];

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        localparam int RES   = i / RESERVOIR_LENGTH;
        localparam int LOC   = i % RESERVOIR_LENGTH;
        localparam int LEFT  = (i + CELLS - 1) % CELLS;
        localparam int RIGHT = (i + 1) % CELLS;

        // later inputs win on duplicate offsets
        always_comb begin
            inj_cells[i] = restart ? start_val : row_reg[i];
            for (int j = 0; j < INPUT_COUNT; j++) begin
                if ((LOC < (1 << MAP_FIELD_W)) && (off_mod[RES][j] == MAP_FIELD_W'(LOC))) begin
                    inj_cells[i] = sym[j];
                end
            end
        end

        assign gen_cells[i] = next_cell(row_reg[LEFT], row_reg[i], row_reg[RIGHT],
                                        three, rule_table_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                row_reg[i] <= START_THREE;
            end
        end else if (cmd.load) begin
            row_reg <= inj_cells;
        end else if (cmd.step) begin
            row_reg <= gen_cells;
        end
    end

    logic [EW-1:0]    iter_ext;
    logic [EW-1:0]    iter_eff;
    logic [CNT_W-1:0] last_idx_reg;
    logic [CNT_W-1:0] gen_cnt_reg;

    always_comb begin
        iter_ext = EW'(iterations_reg);
        if (iter_ext == '0) begin
            iter_eff = EW'(1);
        end else if (iter_ext > EW'(MAX_ITERATIONS)) begin
            iter_eff = EW'(MAX_ITERATIONS);
        end else begin
            iter_eff = iter_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_cnt_reg  <= '0;
            last_idx_reg <= '0;
        end else if (cmd.load) begin
            gen_cnt_reg  <= '0;
            last_idx_reg <= CNT_W'(iter_eff - EW'(1));
        end else if (cmd.step) begin
            gen_cnt_reg  <= gen_cnt_reg + CNT_W'(1);
        end
    end

    logic [M_TDATA_W-1:0] out_bits;
    for (genvar i = 0; i < OUT_CELLS; i++) begin : g_out
        if (i < CELLS) begin : g_used
            assign out_bits[CELL_W*i +: CELL_W] = gen_cells[i];
        end else begin : g_pad
            assign out_bits[CELL_W*i +: CELL_W] = '0;
        end
    end

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_gen_reg;
    logic                 out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            out_data_reg <= out_bits;
            out_gen_reg  <= M_TUSER_W'(gen_cnt_reg);
            out_last_reg <= sts.last_gen;
        end
    end

    assign sts.last_gen = (gen_cnt_reg == last_idx_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_gen_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/cellular_automaton_reservoir_step_unit.sv @@
// ----------------------------------------------------------------------------
// cellular_automaton_reservoir_step_unit
// Cellular automaton reservoir: injects four symbols per item into every
// reservoir of the cell row, then runs the configured number of generations.
// ----------------------------------------------------------------------------
// an item is loaded into the cell row, then each generation goes to the output register
// one generation of the whole row per cycle in the row update logic while the
//   output register is free
// the next item is taken while the last generation still waits on the output
// reset (synchronous, aresetn low): row filled with 2, registers at defaults
`default_nettype none

module cellular_automaton_reservoir_step_unit
    import ca_res_pkg::*;
#(
    parameter int RESERVOIRS       = 4,
    parameter int RESERVOIR_LENGTH = 8,
    parameter int INPUT_COUNT      = 4,
    parameter int MAX_ITERATIONS   = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,  // symbol_a, symbol_b, symbol_c, symbol_d, restart
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,  // row_cells
    output logic [M_TUSER_W-1:0]        m_tuser,  // generation
    output logic                        m_tlast
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    ca_res_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ca_res_dp #(
        .RESERVOIRS       (RESERVOIRS),
        .RESERVOIR_LENGTH (RESERVOIR_LENGTH),
        .INPUT_COUNT      (INPUT_COUNT),
        .MAX_ITERATIONS   (MAX_ITERATIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

@@ rtl/ca_res_check.sv @@
// ----------------------------------------------------------------------------
// ca_res_check
// Port-level checks for the cellular automaton reservoir step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ca_res_check
    import ca_res_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser,
    input wire logic                 m_tlast
);

    // busy in the cycle after taking an item
    a_busy_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken right after an input transfer");

    // no new item while a run is still producing generations
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("input ready before the last generation");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output changed while stalled");

    // generations of one run follow in order
    a_gen_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> m_tuser == $past(m_tuser) + 4'd1)
        else $error("generation index out of order");

endmodule

bind cellular_automaton_reservoir_step_unit ca_res_check u_ca_res_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ bench/tb_cellular_automaton_reservoir_step_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cellular_automaton_reservoir_step_unit
// Drives symbol items into the reservoir step unit under several register
// settings and random idling on both sides. A scoreboard class evolves its
// own copy of the cell row and checks every generation transfer in order.
// ----------------------------------------------------------------------------

module tb_cellular_automaton_reservoir_step_unit;
    import ca_res_pkg::*;

    localparam int ROW_LEN = 32;
    localparam int RES_LEN = 8;
    localparam int GEN_MAX = 16;

    typedef struct packed {
        logic [63:0] cells;
        logic [3:0]  gen;
        logic        last;
    } ca_gen_t;

    class ca_row_scoreboard;
        logic [1:0]  states_q;
        logic [53:0] rule_q;
        logic [4:0]  iters_q;
        logic [47:0] map_q;
        logic [1:0]  cells [ROW_LEN];
        ca_gen_t     expected_gens [$];
        int          errors;

        function new();
            states_q = NUM_STATES_RESET;
            rule_q   = '0;
            iters_q  = ITERATIONS_RESET;
            map_q    = '0;
            errors   = 0;
            refill();
        endfunction

        function int state_count();
            return (states_q >= 2'd3) ? 3 : 2;
        endfunction

        function void refill();
            foreach (cells[i]) cells[i] = (state_count() == 3) ? START_THREE : START_TWO;
        endfunction

        function int digit(logic [1:0] c, int s);
            return (int'(c) > s - 1) ? s - 1 : int'(c);
        endfunction

        function void set_config(logic [1:0] ns, logic [53:0] rule, logic [4:0] gens,
                                 logic [47:0] map);
            states_q = ns;
            rule_q   = rule;
            iters_q  = gens;
            map_q    = map;
        endfunction

        function int pending();
            return expected_gens.size();
        endfunction

        function void note_transfer(logic restart, logic [7:0] syms);
            int         s;
            int         gens;
            int         k;
            int         pos;
            logic [1:0] nxt [ROW_LEN];
            ca_gen_t    gen_row;
            s    = state_count();
            gens = (iters_q == 0) ? 1 : ((iters_q > GEN_MAX) ? GEN_MAX : int'(iters_q));
            if (restart) refill();
            // later symbols overwrite earlier ones on shared offsets
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 4; j++) begin
                    pos = 12 * r + 3 * j;
                    cells[r * RES_LEN + (int'(map_q[pos +: 3]) % RES_LEN)] = syms[2 * j +: 2];
                end
            end
            for (int g = 0; g < gens; g++) begin
                gen_row = '0;
                for (int i = 0; i < ROW_LEN; i++) begin
                    k = s * s * s - 1
                        - (digit(cells[(i + ROW_LEN - 1) % ROW_LEN], s) * s * s
                           + digit(cells[i], s) * s
                           + digit(cells[(i + 1) % ROW_LEN], s));
                    nxt[i] = 2'(digit(rule_q[2 * k +: 2], s));
                    gen_row.cells[2 * i +: 2] = nxt[i];
                end
                cells = nxt;
                gen_row.gen  = 4'(g);
                gen_row.last = (g == gens - 1);
                expected_gens.push_back(gen_row);
            end
        endfunction

        function void check_generation(logic [63:0] cells_in, logic [3:0] gen_in,
                                       logic last_in);
            ca_gen_t exp_row;
            if (expected_gens.size() == 0) begin
                $display("%0t unexpected transfer: row_cells %h generation %0d last %0b",
                         $time, cells_in, gen_in, last_in);
                errors++;
                return;
            end
            exp_row = expected_gens.pop_front();
            if (cells_in !== exp_row.cells) begin
                $display("%0t row_cells mismatch: expected %h actual %h",
                         $time, exp_row.cells, cells_in);
                errors++;
            end
            if (gen_in !== exp_row.gen) begin
                $display("%0t generation mismatch: expected %0d actual %0d",
                         $time, exp_row.gen, gen_in);
                errors++;
            end
            if (last_in !== exp_row.last) begin
                $display("%0t last_generation mismatch: expected %0b actual %0b",
                         $time, exp_row.last, last_in);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_NUM_STATES;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;  // symbol_a, symbol_b, symbol_c, symbol_d, restart
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // row_cells
    logic [M_TUSER_W-1:0]   m_tuser;         // generation
    logic                   m_tlast;

    int   tx_idle_pct   = 0;
    int   rx_idle_pct   = 0;
    logic long_hold_arm = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_count    = 0;

    ca_row_scoreboard row_board = new();

    cellular_automaton_reservoir_step_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_arm && !long_hold_done) begin
            m_tready <= 1'b0;
            if (hold_count == 300) begin
                long_hold_done <= 1'b1;
            end else begin
                hold_count <= hold_count + 1;
            end
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            row_board.check_generation(m_tdata, m_tuser, m_tlast);
        end
    end

    task automatic send_symbols(input logic [7:0] syms, input logic restart);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart, syms};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        row_board.note_transfer(restart, syms);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (row_board.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [1:0] ns, input logic [53:0] rule,
                                  input logic [4:0] gens, input logic [47:0] map);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NUM_STATES;
        cfg_wdata <= CFG_DATA_W'(ns);
        @(posedge aclk);
        cfg_index <= CFG_RULE_TABLE;
        cfg_wdata <= rule;
        @(posedge aclk);
        cfg_index <= CFG_ITERATIONS;
        cfg_wdata <= CFG_DATA_W'(gens);
        @(posedge aclk);
        cfg_index <= CFG_INPUT_MAP;
        cfg_wdata <= CFG_DATA_W'(map);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        row_board.set_config(ns, rule, gens, map);
    endtask

    // all symbol extremes, symbol 3, distinct symbols and restart both ways
    task automatic send_corner_items;
        send_symbols(8'h00, 1'b1);
        send_symbols(8'hFF, 1'b0);
        send_symbols(8'hAA, 1'b0);
        send_symbols(8'hE4, 1'b0);
        send_symbols(8'h1B, 1'b1);
        send_symbols(8'h55, 1'b0);
    endtask

    task automatic send_random_items(input int count);
        for (int n = 0; n < count; n++) begin
            send_symbols(8'($urandom_range(255)), ($urandom_range(9) == 0));
        end
    endtask

    function automatic logic [53:0] rand_rule_word();
        return {22'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [47:0] random_map();
        return {16'($urandom), 32'($urandom)};
    endfunction

    initial begin : stimulus
        logic [4:0] gens;
        repeat (4) @(posedge aclk);
        aresetn     <= 1'b1;
        tx_idle_pct <= 27;
        rx_idle_pct <= 87;

        // reset settings
        send_symbols(8'h00, 1'b0);
        send_symbols(8'hE4, 1'b0);
        send_symbols(8'hFF, 1'b1);
        drain();

        // oversized rule entries, zero iterations, every offset at the top
        write_settings(2'd3, {54{1'b1}}, 5'd0, {48{1'b1}});
        send_corner_items();
        drain();
        // zero state count, saturated iterations, all symbols on one cell per reservoir
        write_settings(2'd0, rand_rule_word(), 5'd31, '0);
        send_corner_items();
        drain();
        write_settings(2'd1, rand_rule_word(), 5'd16, random_map());
        send_corner_items();
        drain();

        for (int p = 0; p < 10; p++) begin
            if (p == 4) begin
                tx_idle_pct <= 87;
                rx_idle_pct <= 27;
            end else if (p == 7) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            if ($urandom_range(99) < 15) begin
                gens = 5'($urandom_range(31, 16));
            end else begin
                gens = 5'($urandom_range(6));
            end
            write_settings(2'($urandom_range(3)), rand_rule_word(), gens, random_map());
            if (p == 7) long_hold_arm <= 1'b1;
            send_random_items(30);
            drain();
        end

        if (row_board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
